FILE: design/base64_stream_decoder_macros.svh
// Assertion helpers for the base64 stream decoder.
// Both expect clk_i in the scope where they are used; B64D_ASSERT also expects rst_ni.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Check on every clock edge outside reset.
`define B64D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check on every clock edge, reset included.
`define B64D_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

FILE: design/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

  // Width of the running byte counter
  localparam int unsigned CountWidth = 16;
  // Width used for counter versus capacity compares
  localparam int unsigned CmpWidth   = CountWidth + 16;

  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned CfgDataWidth  = 16;

  // Register indexes of the configuration port
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_CAPACITY   = 8'd0,
    REG_COUNT_ONLY = 8'd1
  } reg_index_e;

  localparam logic [15:0] CapacityReset = 16'hFFFF;

  // Special characters
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharSpace = 8'h20;

  // Result item kinds
  localparam logic KindData  = 1'b0;
  localparam logic KindFinal = 1'b1;

  // Classification of one character
  typedef struct packed {
    logic       is_nul;
    logic       is_space;
    logic       is_pad;
    logic       is_alpha;
    logic [5:0] sextet;
  } char_class_t;

endpackage

`default_nettype wire

FILE: design/b64d_if.sv
`default_nettype none

// Character input channel
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

// Result output channel
interface b64d_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic        failed;
  logic [15:0] byte_total;

  modport source (output valid, output kind, output data_byte, output failed,
                  output byte_total, input ready);
  modport sink   (input valid, input kind, input data_byte, input failed,
                  input byte_total, output ready);
endinterface

// Configuration write channel
interface b64d_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/b64d_classify.sv
`default_nettype none

// Sort one character into NUL, whitespace, pad, alphabet or other,
// and give the 6-bit value of an alphabet character.
module b64d_classify (
  input  wire logic [7:0]           char_i,
  output b64d_pkg::char_class_t     class_o
);
  import b64d_pkg::*;

  logic       upper, lower, digit;
  logic [7:0] value;

  always_comb begin
    upper = (char_i >= 8'h41) && (char_i <= 8'h5A);
    lower = (char_i >= 8'h61) && (char_i <= 8'h7A);
    digit = (char_i >= 8'h30) && (char_i <= 8'h39);

    // Map the alphabet onto 0..63
    value = 8'd0;
    if (upper)                   value = char_i - 8'h41;
    else if (lower)              value = char_i - 8'h61 + 8'd26;
    else if (digit)              value = char_i - 8'h30 + 8'd52;
    else if (char_i == CharPlus) value = 8'd62;
    else if (char_i == CharSlash) value = 8'd63;

    class_o.is_nul   = (char_i == CharNul);
    class_o.is_space = ((char_i >= 8'd9) && (char_i <= 8'd13)) || (char_i == CharSpace);
    class_o.is_pad   = (char_i == CharPad);
    class_o.is_alpha = upper || lower || digit || (char_i == CharPlus)
                       || (char_i == CharSlash);
    class_o.sextet   = value[5:0];
  end

endmodule

`default_nettype wire

FILE: design/base64_stream_decoder.sv
// Channel   Dir  Payload                                   Accepted when
// char_i    in   character                                 valid && ready
// result_o  out  kind, data_byte, failed, byte_total       valid && ready
// cfg_i     in   index (0 capacity, 1 count_only), data    valid && ready
//
// One character is taken every cycle unless a held result stalls the decode; the
// character is held in the input register, then decoded into the result register.
// The per-character state update is a single classify and compare stage.
// Reset clears the decode state and sets capacity to 65535, count_only to 0.
// A result held by the sink stops the decode stage; the input register still
// takes one more character, then ready drops until the result is taken.
`default_nettype none

`include "base64_stream_decoder_macros.svh"

module base64_stream_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  b64d_char_if.sink     char_i,
  b64d_result_if.source result_o,
  b64d_cfg_if.sink      cfg_i
);
  import b64d_pkg::*;

  typedef enum logic [1:0] {
    PH_DECODE,
    PH_WANT_PAD,
    PH_TRAIL,
    PH_ERROR
  } phase_e;

  // Configuration registers
  logic [15:0] capacity_q;
  logic        count_only_q;

  // Input register
  logic        in_valid_q;
  logic [7:0]  char_q;

  // Decode state
  phase_e                phase_q, phase_d;
  logic [1:0]            quad_q, quad_d;
  logic [7:0]            partial_q, partial_d;
  logic [CountWidth-1:0] done_q, done_d;

  // Result register
  logic        out_valid_q;
  logic        kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic        failed_q, failed_d;
  logic [15:0] total_q, total_d;
  logic        emit_d;

  logic          fire;
  char_class_t   cls;
  logic [CmpWidth-1:0] done_ext, cap_ext, inc_ext;
  logic          checked, cap_full;
  logic [7:0]    byte_new, next_bits;

  b64d_classify u_classify (
    .char_i  (char_q),
    .class_o (cls)
  );

  // Decode stage runs when the input register holds a character and the result register is free or being emptied
  assign fire         = in_valid_q && (!out_valid_q || result_o.ready);
  assign char_i.ready = !in_valid_q || fire;
  assign cfg_i.ready  = 1'b1;

  assign result_o.valid      = out_valid_q;
  assign result_o.kind       = kind_q;
  assign result_o.data_byte  = byte_q;
  assign result_o.failed     = failed_q;
  assign result_o.byte_total = total_q;

  // Counter compares at a width that holds both counter and capacity
  always_comb begin
    done_ext = {16'b0, done_q};
    cap_ext  = {{CountWidth{1'b0}}, capacity_q};
    inc_ext  = done_ext + CmpWidth'(1);
    checked  = !count_only_q;
    cap_full = done_ext >= cap_ext;
  end

  // Assemble the byte completed by this sextet and the bits it leaves over
  always_comb begin
    case (quad_q)
      2'd1: begin
        byte_new  = partial_q | {6'b0, cls.sextet[5:4]};
        next_bits = {cls.sextet[3:0], 4'b0};
      end
      2'd2: begin
        byte_new  = partial_q | {4'b0, cls.sextet[5:2]};
        next_bits = {cls.sextet[1:0], 6'b0};
      end
      2'd3: begin
        byte_new  = partial_q | {2'b0, cls.sextet};
        next_bits = 8'd0;
      end
      default: begin
        byte_new  = 8'd0;
        next_bits = {cls.sextet, 2'b0};
      end
    endcase
  end

  // Next decode state and result for the character in the input register
  always_comb begin
    phase_d   = phase_q;
    quad_d    = quad_q;
    partial_d = partial_q;
    done_d    = done_q;
    emit_d    = 1'b0;
    kind_d    = KindData;
    byte_d    = 8'd0;
    failed_d  = 1'b0;
    total_d   = 16'd0;

    if (cls.is_nul) begin
      // End of string: report and start over
      emit_d = 1'b1;
      kind_d = KindFinal;
      case (phase_q)
        PH_DECODE: failed_d = (quad_q != 2'd0);
        PH_TRAIL:  failed_d = checked && (partial_q != 8'd0);
        default:   failed_d = 1'b1;
      endcase
      total_d   = failed_d ? 16'd0 : done_ext[15:0];
      phase_d   = PH_DECODE;
      quad_d    = 2'd0;
      partial_d = 8'd0;
      done_d    = '0;
    end else if (phase_q == PH_ERROR || cls.is_space) begin
      // Swallow
    end else if (phase_q == PH_WANT_PAD) begin
      phase_d = cls.is_pad ? PH_TRAIL : PH_ERROR;
    end else if (phase_q == PH_TRAIL) begin
      phase_d = PH_ERROR;
    end else if (cls.is_pad) begin
      case (quad_q)
        2'd2:    phase_d = PH_WANT_PAD;
        2'd3:    phase_d = PH_TRAIL;
        default: phase_d = PH_ERROR;
      endcase
    end else if (!cls.is_alpha) begin
      phase_d = PH_ERROR;
    end else if (checked && cap_full) begin
      phase_d = PH_ERROR;
    end else if (quad_q == 2'd0) begin
      partial_d = next_bits;
      quad_d    = 2'd1;
    end else if (done_q == '1) begin
      phase_d = PH_ERROR;
    end else if (checked && (next_bits != 8'd0) && (inc_ext >= cap_ext)) begin
      phase_d = PH_ERROR;
    end else begin
      partial_d = next_bits;
      done_d    = inc_ext[CountWidth-1:0];
      quad_d    = quad_q + 2'd1;
      emit_d    = 1'b1;
      byte_d    = byte_new;
    end
  end

  // Hold input, decode state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      char_q      <= 8'd0;
      phase_q     <= PH_DECODE;
      quad_q      <= 2'd0;
      partial_q   <= 8'd0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KindData;
      byte_q      <= 8'd0;
      failed_q    <= 1'b0;
      total_q     <= 16'd0;
    end else begin
      if (char_i.valid && char_i.ready) begin
        in_valid_q <= 1'b1;
        char_q     <= char_i.character;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end

      if (fire) begin
        phase_q     <= phase_d;
        quad_q      <= quad_d;
        partial_q   <= partial_d;
        done_q      <= done_d;
        out_valid_q <= emit_d;
        kind_q      <= kind_d;
        byte_q      <= byte_d;
        failed_q    <= failed_d;
        total_q     <= total_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q   <= CapacityReset;
      count_only_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_CAPACITY:   capacity_q   <= cfg_i.data;
        REG_COUNT_ONLY: count_only_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Checks
  `B64D_ASSERT(a_nul_clears, fire && cls.is_nul |=> phase_q == PH_DECODE && quad_q == 2'd0 && done_q == '0, "state not cleared after end of string")
  `B64D_ASSERT(a_pad_quad, phase_q == PH_WANT_PAD |-> quad_q == 2'd2, "awaiting second pad outside quad position two")
  `B64D_ASSERT(a_data_counts, fire && emit_d && kind_d == KindData |=> done_q == CountWidth'($past(done_q) + 1'b1), "data item without count advance")
  `B64D_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_q && !in_valid_q, "pipeline not empty in reset")

endmodule

`default_nettype wire
